// ===== hw/rtl/ers_pkg.sv =====
// Shared types, constants and table builder for the exponential range scaler.
// No dependencies; every other file of the block but ers_if imports this package.
package ers_pkg;

    // Pipeline depth, from input register to result register
    localparam int NUM_STAGES = 14;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_LINEAR_MODE   = 3'd0,
        CFG_INPUT_GAIN    = 3'd1,
        CFG_INPUT_OFFSET  = 3'd2,
        CFG_OUTPUT_GAIN   = 3'd3,
        CFG_OUTPUT_OFFSET = 3'd4
    } cfg_idx_t;

    // Register reset values
    localparam logic        RST_LINEAR_MODE = 1'b1;
    localparam logic [31:0] RST_INPUT_GAIN  = 32'd16777216;

    // Fixed-point constants
    localparam logic [29:0]        LN2_Q30     = 30'd744261118;
    localparam logic [30:0]        INV_LN2_Q30 = 31'd1549082005;
    localparam logic [30:0]        ONE_Q30     = 31'h4000_0000;
    localparam logic signed [40:0] EXP_LIMIT   = 41'sd4194304;
    localparam logic signed [40:0] LIN_MAX     = 41'sd2147483647;
    localparam logic signed [40:0] LIN_MIN     = -41'sd2147483648;
    localparam logic signed [63:0] WIDE_LIMIT  = 64'sd1099511627776;
    localparam logic signed [31:0] SAT_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN     = 32'sh8000_0000;

    // floor(v / 6) as a reciprocal multiply, exact for v below 2^19
    localparam logic [17:0] DIV6_RECIP = 18'd174763;
    localparam int          DIV6_SHIFT = 20;

    // Datapath widths
    localparam int Y_W    = 54;
    localparam int K_W    = 8;
    localparam int Z_W    = 26;
    localparam int Z2_W   = 21;
    localparam int Z3_W   = 17;
    localparam int POLY_W = 31;
    localparam int TAB_W  = 31;
    localparam int MANT_W = 32;

    // Result that bypasses the exponential path, or a marker that it is needed
    typedef struct packed {
        logic        is_exp;
        logic [31:0] value;
        logic        sat;
    } byp_t;

    // One table entry: 2^(i/N) in Q30 from a Taylor series truncated after the 14th power
    function automatic logic [TAB_W-1:0] pow2_entry(input logic [63:0] arg);
        logic [63:0] term;
        logic [63:0] sum;
        term = 64'd1 << 30;
        sum  = term;
        term = ((term * arg) >> 30) / 64'd1;  sum = sum + term;
        term = ((term * arg) >> 30) / 64'd2;  sum = sum + term;
        term = ((term * arg) >> 30) / 64'd3;  sum = sum + term;
        term = ((term * arg) >> 30) / 64'd4;  sum = sum + term;
        term = ((term * arg) >> 30) / 64'd5;  sum = sum + term;
        term = ((term * arg) >> 30) / 64'd6;  sum = sum + term;
        term = ((term * arg) >> 30) / 64'd7;  sum = sum + term;
        term = ((term * arg) >> 30) / 64'd8;  sum = sum + term;
        term = ((term * arg) >> 30) / 64'd9;  sum = sum + term;
        term = ((term * arg) >> 30) / 64'd10; sum = sum + term;
        term = ((term * arg) >> 30) / 64'd11; sum = sum + term;
        term = ((term * arg) >> 30) / 64'd12; sum = sum + term;
        term = ((term * arg) >> 30) / 64'd13; sum = sum + term;
        term = ((term * arg) >> 30) / 64'd14; sum = sum + term;
        return sum[TAB_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/ers_if.sv =====
// Handshake channels of the exponential range scaler: input, result, config.
// Depends on nothing; the top level and its user connect through these.
interface ers_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] in_value;

    modport source (output valid, output in_value, input ready);
    modport sink   (input valid, input in_value, output ready);
endinterface

interface ers_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_value;
    logic               saturated;

    modport source (output valid, output out_value, output saturated, input ready);
    modport sink   (input valid, input out_value, input saturated, output ready);
endinterface

interface ers_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/ers_front.sv =====
// Front stages: input gain multiply, offset add, range classification and
// scaling by 1/ln2. Depends on ers_pkg.
module ers_front (
    input  logic                              clk,
    input  logic [ers_pkg::NUM_STAGES-1:0]    en,
    input  logic signed [31:0]                in_value,
    input  logic                              linear_mode,
    input  logic signed [31:0]                input_gain,
    input  logic signed [31:0]                input_offset,
    input  logic signed [31:0]                output_gain,
    input  logic signed [31:0]                output_offset,
    output logic signed [ers_pkg::Y_W-1:0]    y,
    output ers_pkg::byp_t                     byp
);
    import ers_pkg::*;

    logic signed [63:0]    prod_reg, prod_next;
    logic signed [40:0]    a_reg, a_next;
    logic signed [Y_W-1:0] y_reg, y_next;
    byp_t                  byp_reg, byp_next;
    logic signed [22:0]    a_small;
    logic                  ovf, unf, lin_hi, lin_lo;

    // Stage 0: scale the input by the Q8.24 gain
    assign prod_next = 64'(in_value) * 64'(input_gain);

    // Stage 1: drop the gain fraction and add the offset
    assign a_next = 41'(prod_reg >>> 24) + 41'(input_offset);

    // Stage 2: classify the argument and form a/ln2
    always_comb
    begin
        ovf      = (a_reg >= EXP_LIMIT);
        unf      = (a_reg < -EXP_LIMIT);
        lin_hi   = (a_reg > LIN_MAX);
        lin_lo   = (a_reg < LIN_MIN);
        a_small  = $signed(a_reg[22:0]);
        y_next   = Y_W'(a_small) * Y_W'($signed({1'b0, INV_LN2_Q30}));

        byp_next.is_exp = 1'b0;
        byp_next.value  = output_offset;
        byp_next.sat    = 1'b0;
        if (linear_mode)
        begin
            byp_next.sat   = lin_hi | lin_lo;
            byp_next.value = lin_hi ? SAT_MAX : (lin_lo ? SAT_MIN : a_reg[31:0]);
        end
        else if (ovf)
        begin
            if (output_gain != 32'sd0)
            begin
                byp_next.sat   = 1'b1;
                byp_next.value = output_gain[31] ? SAT_MIN : SAT_MAX;
            end
        end
        else if (!unf)
        begin
            byp_next.is_exp = 1'b1;
        end
    end

    // Advance each stage when its enable is set
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg <= prod_next;
        end
        if (en[1])
        begin
            a_reg <= a_next;
        end
        if (en[2])
        begin
            y_reg   <= y_next;
            byp_reg <= byp_next;
        end
    end

    assign y   = y_reg;
    assign byp = byp_reg;

endmodule

// ===== hw/rtl/ers_exp.sv =====
// Exponential core: splits a/ln2 into integer and fraction, looks up 2^(i/N)
// and refines it with a cubic polynomial. Depends on ers_pkg.
module ers_exp #(
    parameter int EXP_TABLE_ENTRIES = 64
) (
    input  logic                              clk,
    input  logic [ers_pkg::NUM_STAGES-1:0]    en,
    input  logic signed [ers_pkg::Y_W-1:0]    y,
    output logic [ers_pkg::MANT_W-1:0]        mant,
    output logic signed [ers_pkg::K_W-1:0]    k
);
    import ers_pkg::*;

    localparam int IW     = $clog2(EXP_TABLE_ENTRIES);
    localparam int FN_W   = 32 + IW;
    localparam int RSHIFT = 30 + IW;
    // ceil(2^(30+IW)/N): floor(v/N) for any 30-bit v
    localparam logic [31:0] RECIP = 32'(((64'd1 << RSHIFT) + 64'(EXP_TABLE_ENTRIES) - 64'd1)
                                        / 64'(EXP_TABLE_ENTRIES));

    logic [TAB_W-1:0]      tab [EXP_TABLE_ENTRIES];

    logic signed [K_W-1:0] k_reg [3:9];
    logic [FN_W-1:0]       fn_reg, fn_next;
    logic [29:0]           z0_reg, z0_next;
    logic [TAB_W-1:0]      tab4_reg, tab5_reg, tab6_reg, tab7_reg, tab8_reg;
    logic [Z_W-1:0]        z5_reg, z6_reg, z7_reg, z_next;
    logic [Z2_W-1:0]       z2_6_reg, z2_7_reg, z2_next;
    logic [Z3_W-1:0]       z3_reg, z3_next;
    logic [Z3_W-1:0]       z3_div6;
    logic [POLY_W-1:0]     poly_reg, poly_next;
    logic [MANT_W-1:0]     mant_reg, mant_next;
    logic [IW-1:0]         idx;

    // Build the 2^(i/N) table at elaboration
    for (genvar g = 0; g < EXP_TABLE_ENTRIES; g++)
    begin : g_tab
        localparam logic [63:0] ARG = (64'(g) * 64'(LN2_Q30)) / 64'(EXP_TABLE_ENTRIES);
        assign tab[g] = pow2_entry(ARG);
    end

    always_comb
    begin
        // Stage 3: fraction of a/ln2 times N
        fn_next   = FN_W'(y[45:14]) * FN_W'(EXP_TABLE_ENTRIES);
        // Stage 4: table index and remainder in natural-log units
        idx       = fn_reg[FN_W-1:32];
        z0_next   = 30'((62'(fn_reg[31:0]) * 62'(LN2_Q30)) >> 32);
        // Stage 5: divide the remainder by N
        z_next    = Z_W'((62'(z0_reg) * 62'(RECIP)) >> RSHIFT);
        // Stage 6, 7: powers of z
        z2_next   = Z2_W'((52'(z5_reg) * 52'(z5_reg)) >> 30);
        z3_next   = Z3_W'((47'(z2_6_reg) * 47'(z6_reg)) >> 30);
        // Stage 8: cubic polynomial
        z3_div6   = Z3_W'((35'(z3_reg) * 35'(DIV6_RECIP)) >> DIV6_SHIFT);
        poly_next = ONE_Q30 + POLY_W'(z7_reg) + POLY_W'(z2_7_reg >> 1) + POLY_W'(z3_div6);
        // Stage 9: table value times polynomial
        mant_next = MANT_W'((62'(tab8_reg) * 62'(poly_reg)) >> 30);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            k_reg[3] <= $signed(y[Y_W-1:46]);
            fn_reg   <= fn_next;
        end
        if (en[4])
        begin
            k_reg[4] <= k_reg[3];
            z0_reg   <= z0_next;
            tab4_reg <= tab[idx];
        end
        if (en[5])
        begin
            k_reg[5] <= k_reg[4];
            z5_reg   <= z_next;
            tab5_reg <= tab4_reg;
        end
        if (en[6])
        begin
            k_reg[6] <= k_reg[5];
            z6_reg   <= z5_reg;
            z2_6_reg <= z2_next;
            tab6_reg <= tab5_reg;
        end
        if (en[7])
        begin
            k_reg[7] <= k_reg[6];
            z7_reg   <= z6_reg;
            z2_7_reg <= z2_6_reg;
            z3_reg   <= z3_next;
            tab7_reg <= tab6_reg;
        end
        if (en[8])
        begin
            k_reg[8] <= k_reg[7];
            poly_reg <= poly_next;
            tab8_reg <= tab7_reg;
        end
        if (en[9])
        begin
            k_reg[9] <= k_reg[8];
            mant_reg <= mant_next;
        end
    end

    assign mant = mant_reg;
    assign k    = k_reg[9];

endmodule

// ===== hw/rtl/ers_scale.sv =====
// Output stages: gain multiply, power-of-two shift with rounding, offset add,
// saturation and final result select. Depends on ers_pkg.
module ers_scale (
    input  logic                              clk,
    input  logic [ers_pkg::NUM_STAGES-1:0]    en,
    input  logic [ers_pkg::MANT_W-1:0]        mant,
    input  logic signed [ers_pkg::K_W-1:0]    k,
    input  logic signed [31:0]                output_gain,
    input  logic signed [31:0]                output_offset,
    input  ers_pkg::byp_t                     byp,
    output logic signed [31:0]                out_value,
    output logic                              saturated
);
    import ers_pkg::*;

    logic signed [63:0]    p_reg, p_next;
    logic signed [K_W-1:0] k_reg;
    logic signed [63:0]    val_reg, val_next;
    logic                  rnd_reg, rnd_next;
    logic                  big_reg, big_next;
    logic signed [41:0]    r_reg;
    logic                  wide_reg, wide_next;
    logic                  pos_reg, pos_next;
    logic signed [31:0]    out_reg, out_next;
    logic                  sat_reg, sat_next;
    logic signed [8:0]     s_amt;
    logic [5:0]            shr, shl;
    logic signed [63:0]    lim, r_full;
    logic signed [42:0]    sum;

    // Stage 10: scale the exponential by the output gain
    assign p_next = 64'(output_gain) * $signed({32'd0, mant});

    // Stage 11: shift by 2^(k-30); right shifts keep one bit for rounding
    always_comb
    begin
        s_amt    = 9'sd30 - 9'(k_reg);
        shr      = 6'(s_amt - 9'sd1);
        shl      = 6'(-s_amt);
        lim      = (shl < 6'd32) ? (64'sd1 <<< (6'd40 - shl)) : 64'sd0;
        val_next = p_reg;
        rnd_next = 1'b0;
        big_next = 1'b0;
        if (s_amt >= 9'sd63)
        begin
            val_next = 64'sd0;
        end
        else if (s_amt > 9'sd0)
        begin
            val_next = p_reg >>> shr;
            rnd_next = 1'b1;
        end
        else if (s_amt < 9'sd0)
        begin
            if (p_reg != 64'sd0 && (shl >= 6'd32 || p_reg > lim || p_reg < -lim))
            begin
                big_next = 1'b1;
            end
            else
            begin
                val_next = p_reg <<< shl;
            end
        end
    end

    // Stage 12: round half up and flag values beyond 2^40
    always_comb
    begin
        r_full    = rnd_reg ? ((val_reg + 64'sd1) >>> 1) : val_reg;
        wide_next = big_reg || (r_full > WIDE_LIMIT) || (r_full < -WIDE_LIMIT);
        pos_next  = ~val_reg[63];
        if (!big_reg)
        begin
            pos_next = ~r_full[63];
        end
    end

    // Stage 13: add the offset, saturate, pick the bypass where it applies
    always_comb
    begin
        sum      = 43'(r_reg) + 43'(output_offset);
        out_next = sum[31:0];
        sat_next = 1'b0;
        if (!byp.is_exp)
        begin
            out_next = byp.value;
            sat_next = byp.sat;
        end
        else if (wide_reg)
        begin
            out_next = pos_reg ? SAT_MAX : SAT_MIN;
            sat_next = 1'b1;
        end
        else if (sum > 43'(SAT_MAX))
        begin
            out_next = SAT_MAX;
            sat_next = 1'b1;
        end
        else if (sum < 43'(SAT_MIN))
        begin
            out_next = SAT_MIN;
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            p_reg <= p_next;
            k_reg <= k;
        end
        if (en[11])
        begin
            val_reg <= val_next;
            rnd_reg <= rnd_next;
            big_reg <= big_next;
        end
        if (en[12])
        begin
            r_reg    <= r_full[41:0];
            wide_reg <= wide_next;
            pos_reg  <= pos_next;
        end
        if (en[13])
        begin
            out_reg <= out_next;
            sat_reg <= sat_next;
        end
    end

    assign out_value = out_reg;
    assign saturated = sat_reg;

endmodule

// ===== hw/rtl/exponential_range_scaler_unit.sv =====
// Exponential range scaler: maps each signed Q16.16 item either linearly
// (value*input_gain + input_offset) or through output_gain*exp(.)+output_offset,
// saturating to 32 bits. The block is a 14-stage pipeline: it takes one item per
// clock while the pipeline is not held full by a result-side stall, with no
// internal state between items. Stalls on the result side hold the pipeline
// without loss, and bubbles inside it are squeezed out, so input is still taken
// while a finished result waits, as long as some stage is empty. The exponential
// path is paced by its chain of registered multipliers (gain, 1/ln2, remainder,
// powers, table and output gain); each sits in a stage of its own. Configuration
// writes are always accepted and must only be issued while no item is in flight.
// Depends on ers_pkg, ers_if, ers_front, ers_exp and ers_scale.
module exponential_range_scaler_unit #(
    parameter int EXP_TABLE_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    ers_in_if.sink      sample,
    ers_out_if.source   result,
    ers_cfg_if.sink     cfg
);
    import ers_pkg::*;

    logic                  linear_mode_reg;
    logic signed [31:0]    input_gain_reg;
    logic signed [31:0]    input_offset_reg;
    logic signed [31:0]    output_gain_reg;
    logic signed [31:0]    output_offset_reg;

    logic [NUM_STAGES-1:0] vld_reg, vld_next;
    logic [NUM_STAGES-1:0] en;

    logic signed [Y_W-1:0] y;
    byp_t                  byp_front;
    byp_t                  byp_reg [3:12];
    logic [MANT_W-1:0]     mant;
    logic signed [K_W-1:0] k;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_mode_reg   <= RST_LINEAR_MODE;
            input_gain_reg    <= RST_INPUT_GAIN;
            input_offset_reg  <= 32'sd0;
            output_gain_reg   <= 32'sd0;
            output_offset_reg <= 32'sd0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_LINEAR_MODE:   linear_mode_reg   <= cfg.data[0];
                CFG_INPUT_GAIN:    input_gain_reg    <= cfg.data;
                CFG_INPUT_OFFSET:  input_offset_reg  <= cfg.data;
                CFG_OUTPUT_GAIN:   output_gain_reg   <= cfg.data;
                CFG_OUTPUT_OFFSET: output_offset_reg <= cfg.data;
                default:           ;
            endcase
        end
    end

    // Stage enables: a stage moves when it is empty, when some later stage can move, or when the result side is ready
    for (genvar j = 0; j < NUM_STAGES; j++)
    begin : g_en
        assign en[j] = result.ready | ~(&vld_reg[NUM_STAGES-1:j]);
    end

    // Advance valid bits with the data
    always_comb
    begin
        for (int j = 0; j < NUM_STAGES; j++)
        begin
            vld_next[j] = vld_reg[j];
        end
        if (en[0])
        begin
            vld_next[0] = sample.valid;
        end
        for (int j = 1; j < NUM_STAGES; j++)
        begin
            if (en[j])
            begin
                vld_next[j] = vld_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign sample.ready = en[0];
    assign result.valid = vld_reg[NUM_STAGES-1];

    // Carry the bypass result alongside the exponential path
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            byp_reg[3] <= byp_front;
        end
        for (int j = 4; j <= 12; j++)
        begin
            if (en[j])
            begin
                byp_reg[j] <= byp_reg[j-1];
            end
        end
    end

    ers_front u_front (
        .clk           (clk),
        .en            (en),
        .in_value      (sample.in_value),
        .linear_mode   (linear_mode_reg),
        .input_gain    (input_gain_reg),
        .input_offset  (input_offset_reg),
        .output_gain   (output_gain_reg),
        .output_offset (output_offset_reg),
        .y             (y),
        .byp           (byp_front)
    );

    ers_exp #(
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_exp (
        .clk  (clk),
        .en   (en),
        .y    (y),
        .mant (mant),
        .k    (k)
    );

    ers_scale u_scale (
        .clk           (clk),
        .en            (en),
        .mant          (mant),
        .k             (k),
        .output_gain   (output_gain_reg),
        .output_offset (output_offset_reg),
        .byp           (byp_reg[12]),
        .out_value     (result.out_value),
        .saturated     (result.saturated)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the exponential range scaler: directed corner items, then random
// register settings and items, each result checked against a built-in predictor.
// Depends on ers_pkg, the ers_*_if interfaces and exponential_range_scaler_unit.
module tb_top;
    import ers_pkg::*;

    localparam int          TAB_N         = 64;
    localparam int          CLK_HALF      = 4;
    localparam int          TIMEOUT_NS    = 5_000_000;
    localparam int          RANDOM_ITEMS  = 1500;
    localparam int          Q16_ONE       = 65536;
    localparam int          CFG_INDEX_TOP = 7;
    localparam logic [31:0] GAIN_ONE      = 32'h0100_0000;

    typedef longint unsigned u64_t;

    localparam longint EXP_SPAN   = 64'sd4194304;        // 64.0 in Q16.16
    localparam longint RECIP_LN2  = 64'sd1549082005;     // 1/ln2 in Q30
    localparam u64_t   LN2_FRAC   = 64'd744261118;       // ln2 in Q30
    localparam u64_t   UNITY_Q30  = 64'd1073741824;
    localparam longint HUGE_BOUND = 64'sd1099511627776;  // 2^40
    localparam longint WORD_MAX   = 64'sd2147483647;
    localparam longint WORD_MIN   = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } map_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    // Register copy, power-of-two table and queue of mapped results still due
    class map_scoreboard;
        logic   lin_mode;
        longint in_gain;
        longint in_offset;
        longint out_gain;
        longint out_offset;
        u64_t   pow2_lut[TAB_N];
        map_t   pending_maps[$];
        int     errors;

        function new();
            u64_t arg;
            u64_t term;
            u64_t sum;
            errors     = 0;
            lin_mode   = 1'b1;
            in_gain    = longint'(GAIN_ONE);
            in_offset  = 0;
            out_gain   = 0;
            out_offset = 0;
            // 2^(i/N) in Q30 from a series of exp(i*ln2/N) truncated after the 14th power
            for (int i = 0; i < TAB_N; i++)
            begin
                arg  = (u64_t'(i) * LN2_FRAC) / u64_t'(TAB_N);
                term = UNITY_Q30;
                sum  = UNITY_Q30;
                for (int n = 1; n <= 14; n++)
                begin
                    term = ((term * arg) >> 30) / u64_t'(n);
                    sum  = sum + term;
                end
                pow2_lut[i] = sum;
            end
        endfunction

        function void write_reg(input logic [2:0] idx, input logic [31:0] data);
            case (idx)
                CFG_LINEAR_MODE:   lin_mode   = data[0];
                CFG_INPUT_GAIN:    in_gain    = longint'(signed'(data));
                CFG_INPUT_OFFSET:  in_offset  = longint'(signed'(data));
                CFG_OUTPUT_GAIN:   out_gain   = longint'(signed'(data));
                CFG_OUTPUT_OFFSET: out_offset = longint'(signed'(data));
                default: ;
            endcase
        endfunction

        function map_t clip_word(input longint v);
            map_t res;
            res.sat = 1'b0;
            if (v > WORD_MAX)
            begin
                res.value = 32'h7FFF_FFFF;
                res.sat   = 1'b1;
            end
            else if (v < WORD_MIN)
            begin
                res.value = 32'h8000_0000;
                res.sat   = 1'b1;
            end
            else
                res.value = 32'(v);
            return res;
        endfunction

        function map_t map_value(input logic signed [31:0] x);
            map_t   res;
            longint a;
            longint y;
            longint k;
            longint p;
            longint r;
            longint s;
            longint sh;
            longint lim;
            u64_t   f;
            u64_t   fn;
            u64_t   idx;
            u64_t   z;
            u64_t   z2;
            u64_t   z3;
            u64_t   poly;
            u64_t   m;
            logic   big;
            big = 1'b0;
            a = ((longint'(x) * in_gain) >>> 24) + in_offset;
            if (lin_mode)
                res = clip_word(a);
            else if (a >= EXP_SPAN)
            begin
                // exp overflow: clip toward the sign of the gain unless it is zero
                if (out_gain == 0)
                    res = clip_word(out_offset);
                else
                begin
                    res.sat   = 1'b1;
                    res.value = (out_gain > 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                end
            end
            else if (a < -EXP_SPAN)
                res = clip_word(out_offset);
            else
            begin
                // reduce to 2^k * 2^f, split f into table step and remainder
                y   = a * RECIP_LN2;
                k   = y >>> 46;
                f   = u64_t'(y - (k <<< 46)) >> 14;
                fn  = f * u64_t'(TAB_N);
                idx = fn >> 32;
                z   = (((fn & 64'hFFFF_FFFF) * LN2_FRAC) >> 32) / u64_t'(TAB_N);
                z2  = (z * z) >> 30;
                z3  = (z2 * z) >> 30;
                poly = UNITY_Q30 + z + z2 / 2 + z3 / 6;
                if (idx >= u64_t'(TAB_N))
                    idx = u64_t'(TAB_N - 1);
                m = (pow2_lut[idx] * poly) >> 30;
                p = out_gain * longint'(m);
                s = 30 - k;
                // scale by 2^(k-30), rounding half up on a right shift
                if (s >= 63)
                    r = 0;
                else if (s > 0)
                    r = (p + (longint'(1) <<< (s - 1))) >>> s;
                else if (s == 0)
                    r = p;
                else
                begin
                    sh  = -s;
                    lim = HUGE_BOUND >>> sh;
                    if (p != 0 && (sh >= 32 || p > lim || p < -lim))
                    begin
                        big = 1'b1;
                        r   = (p > 0) ? HUGE_BOUND + 1 : -HUGE_BOUND - 1;
                    end
                    else
                        r = p <<< sh;
                end
                if (big || r > HUGE_BOUND || r < -HUGE_BOUND)
                begin
                    res.sat   = 1'b1;
                    res.value = (r > 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                end
                else
                    res = clip_word(r + out_offset);
            end
            return res;
        endfunction

        function void note_sample(input logic [31:0] x);
            pending_maps.push_back(map_value(x));
        endfunction

        function void check_result(input logic [31:0] v, input logic s);
            map_t want;
            if (pending_maps.size() == 0)
            begin
                errors++;
                $display("%0t: result with no item pending: expected none, actual %h/%b",
                         $time, v, s);
            end
            else
            begin
                want = pending_maps.pop_front();
                if (v !== want.value)
                begin
                    errors++;
                    $display("%0t: out_value expected %h actual %h", $time, want.value, v);
                end
                if (s !== want.sat)
                begin
                    errors++;
                    $display("%0t: saturated expected %b actual %b", $time, want.sat, s);
                end
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    ers_in_if      in_ch();
    ers_out_if     out_ch();
    ers_cfg_if     cfg_ch();
    map_scoreboard sb;

    exponential_range_scaler_unit #(
        .EXP_TABLE_ENTRIES (TAB_N)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (in_ch),
        .result (out_ch),
        .cfg    (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Watch all three handshakes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.index, cfg_ch.data);
            if (in_ch.valid && in_ch.ready)
                sb.note_sample(in_ch.in_value);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.out_value, out_ch.saturated);
        end
    end

    // Stall the result side, switching among open, light, heavy and periodic patterns
    initial
    begin
        rx_mode_t stall_mode;
        int       mode_left;
        stall_mode = RX_OPEN;
        mode_left  = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                stall_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(16, 200);
            end
            mode_left--;
            case (stall_mode)
                RX_OPEN:   out_ch.ready <= 1'b1;
                RX_LIGHT:  out_ch.ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY:  out_ch.ready <= ($urandom_range(0, 3) == 0);
                default:   out_ch.ready <= ((mode_left % 8) >= 3);
            endcase
        end
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offer one item and hold it until taken
    task automatic push_sample(input logic [31:0] v);
        in_ch.valid    <= 1'b1;
        in_ch.in_value <= v;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic wait_drain();
        while (sb.pending_maps.size() != 0)
            @(posedge clk);
    endtask

    // Drop valid, let every result out and the pipeline empty
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait_drain();
        repeat (NUM_STAGES + 2) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    task automatic cfg_done();
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic lin, input logic [31:0] ig, input logic [31:0] io,
                            input logic [31:0] og, input logic [31:0] oo);
        settle();
        cfg_write(CFG_LINEAR_MODE, {31'd0, lin});
        cfg_write(CFG_INPUT_GAIN, ig);
        cfg_write(CFG_INPUT_OFFSET, io);
        cfg_write(CFG_OUTPUT_GAIN, og);
        cfg_write(CFG_OUTPUT_OFFSET, oo);
        cfg_done();
    endtask

    // Mostly a value within +/-2^span, sometimes any word, an extreme or zero
    function automatic logic [31:0] random_word(input int span_log2);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return 32'(int'($urandom_range(0, 1 << (span_log2 + 1))) - (1 << span_log2));
        else if (pick < 17)
            return $urandom;
        else if (pick == 17)
            return 32'h7FFF_FFFF;
        else if (pick == 18)
            return 32'h8000_0000;
        return 32'h0;
    endfunction

    // Mostly inputs that land inside the exp range, plus noise and extremes
    function automatic logic [31:0] pick_sample();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 11)
            return 32'(int'($urandom_range(0, 64 * Q16_ONE)) - 32 * Q16_ONE);
        else if (pick < 16)
            return $urandom;
        else if (pick < 18)
            return 32'(int'($urandom_range(0, 8192)) - 4096);
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'(64 * Q16_ONE);
            3:       return 32'(-64 * Q16_ONE);
            4:       return 32'(-64 * Q16_ONE - 1);
            default: return 32'h0;
        endcase
    endfunction

    // One random register setting, then bursts of items with random gaps
    task automatic run_random_phase(input int count);
        int          left;
        int          burst;
        int          gap;
        logic [31:0] ig;
        logic [2:0]  junk_idx;
        ig = ($urandom_range(0, 3) == 0) ? GAIN_ONE : random_word(25);
        set_regs(($urandom_range(0, 2) == 0), ig, random_word(20), random_word(18),
                 random_word(20));
        if ($urandom_range(0, 3) == 0)
        begin
            junk_idx = 3'($urandom_range(int'(CFG_OUTPUT_OFFSET) + 1, CFG_INDEX_TOP));
            cfg_write(junk_idx, $urandom);
            cfg_done();
        end
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 40);
            if (burst > left)
                burst = left;
            repeat (burst) push_sample(pick_sample());
            left -= burst;
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if ($urandom_range(0, 24) == 0)
            begin
                // hold off until every result is out
                in_ch.valid <= 1'b0;
                @(posedge clk);
                wait_drain();
            end
            else if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        int sent;
        int n;
        sb = new();
        rst_n          <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.in_value <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= '0;
        cfg_ch.data    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: linear at unity gain
        push_sample(32'h0000_0000);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);
        push_sample(32'h0000_0001);
        push_sample(32'hFFFF_FFFF);

        // Linear saturation at both gain and offset extremes
        set_regs(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);
        push_sample(32'h0000_0000);
        set_regs(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);

        // Writes past the register list must leave everything alone
        set_regs(1'b1, GAIN_ONE, 32'h0, 32'h0, 32'h0);
        for (int j = int'(CFG_OUTPUT_OFFSET) + 1; j <= CFG_INDEX_TOP; j++)
            cfg_write(3'(j), 32'h0);
        cfg_done();
        push_sample(32'(Q16_ONE));

        // Exp mode at unity gains: core, overflow, range edge, underflow
        set_regs(1'b0, GAIN_ONE, 32'h0, 32'(Q16_ONE), 32'h0);
        push_sample(32'h0000_0000);
        push_sample(32'(64 * Q16_ONE));
        push_sample(32'(-64 * Q16_ONE));
        push_sample(32'(-64 * Q16_ONE - 1));
        push_sample(32'h003F_FFFF);
        push_sample(32'(10 * Q16_ONE));
        push_sample(32'(-10 * Q16_ONE));
        push_sample(32'(Q16_ONE));

        // Overflow with zero and negative output gain
        set_regs(1'b0, GAIN_ONE, 32'h0, 32'h0, 32'h7FFF_FFFF);
        push_sample(32'(100 * Q16_ONE));
        set_regs(1'b0, GAIN_ONE, 32'h0, 32'hFFFF_0000, 32'h0);
        push_sample(32'(100 * Q16_ONE));

        // Huge scaled exp in both signs, then clip on the output offset
        set_regs(1'b0, GAIN_ONE, 32'h0, 32'h7FFF_FFFF, 32'h0);
        push_sample(32'(40 * Q16_ONE));
        set_regs(1'b0, GAIN_ONE, 32'h0, 32'h8000_0000, 32'h0);
        push_sample(32'(40 * Q16_ONE));
        set_regs(1'b0, GAIN_ONE, 32'h0, 32'(Q16_ONE), 32'h7FFF_FFFF);
        push_sample(32'(Q16_ONE));

        // Random settings and items
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            n = $urandom_range(60, 190);
            if (n > RANDOM_ITEMS - sent)
                n = RANDOM_ITEMS - sent;
            run_random_phase(n);
            sent += n;
        end

        // Drain and give stray results time to show up
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait_drain();
        repeat (2 * NUM_STAGES) @(posedge clk);
        if (sb.errors == 0 && sb.pending_maps.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
